// File: rtl/suffix_automaton_matcher_defines.svh
// Assertion macros shared by the suffix automaton matcher RTL.
`ifndef SUFFIX_AUTOMATON_MATCHER_DEFINES_SVH
`define SUFFIX_AUTOMATON_MATCHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SAM_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SAM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: rtl/sam_pkg.sv
// Types and constants for the suffix automaton matcher.
package sam_pkg;
  localparam int unsigned SymW = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_AP_CLR,
    ST_AP_RDP,
    ST_AP_CHKP,
    ST_AP_RDQ,
    ST_AP_CHKQ,
    ST_AP_COPYRD,
    ST_AP_COPY,
    ST_AP_REDIR,
    ST_AP_REDIRW,
    ST_AP_QLINK,
    ST_AP_FIN,
    ST_MA_RD,
    ST_MA_CHK,
    ST_MA_DONE,
    ST_START,
    ST_STARTW
  } sam_state_t;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_MATCH  = 1'b1
  } sam_op_t;

  typedef enum logic {
    STAT_OK   = 1'b0,
    STAT_FULL = 1'b1
  } sam_status_t;
endpackage

// File: rtl/sam_store.sv
// Automaton memories: transitions, lengths, links and end positions.
module sam_store #(
  parameter int unsigned SW = 11,
  parameter int unsigned PW = 10,
  parameter int unsigned AW = 5,
  parameter int unsigned ALPHABET = 26
) (
  input  logic          clk,
  input  logic          tr_we,
  input  logic [SW-1:0] tr_wstate,
  input  logic [AW-1:0] tr_wsym,
  input  logic [SW-1:0] tr_wdata,
  input  logic [SW-1:0] tr_rstate,
  input  logic [AW-1:0] tr_rsym,
  output logic [SW-1:0] tr_rdata,
  input  logic          nd_we,
  input  logic [SW-1:0] nd_waddr,
  input  logic [SW-1:0] nd_wlen,
  input  logic [SW-1:0] nd_wlink,
  input  logic [PW-1:0] nd_wpos,
  input  logic [SW-1:0] nd_raddr,
  output logic [SW-1:0] nd_rlen,
  output logic [SW-1:0] nd_rlink,
  output logic [PW-1:0] nd_rpos
);
  localparam int unsigned Depth = 1 << SW;
  localparam int unsigned TDepth = Depth * ALPHABET;
  localparam int unsigned TW = $clog2(TDepth);

  logic [SW-1:0] tr_mem [TDepth];
  logic [SW-1:0] len_mem [Depth];
  logic [SW-1:0] link_mem [Depth];
  logic [PW-1:0] pos_mem [Depth];

  logic [TW-1:0] tr_wa, tr_ra;
  assign tr_wa = TW'(tr_wstate * ALPHABET + tr_wsym);
  assign tr_ra = TW'(tr_rstate * ALPHABET + tr_rsym);

  // Transition table, one write and one read port
  always_ff @(posedge clk) begin
    if (tr_we) tr_mem[tr_wa] <= tr_wdata;
    tr_rdata <= tr_mem[tr_ra];
  end

  // Per-state fields written together
  always_ff @(posedge clk) begin
    if (nd_we) begin
      len_mem[nd_waddr]  <= nd_wlen;
      link_mem[nd_waddr] <= nd_wlink;
      pos_mem[nd_waddr]  <= nd_wpos;
    end
    nd_rlen  <= len_mem[nd_raddr];
    nd_rlink <= link_mem[nd_raddr];
    nd_rpos  <= pos_mem[nd_raddr];
  end
endmodule

// File: rtl/suffix_automaton_matcher.sv
// Top level of the suffix automaton matcher: sequencer and shared adder.
//
//  channel | signals                              | direction
//  in      | in_valid in_ready op symbol restart  | into block
//  out     | out_valid out_ready status states_used match_length
//          | best_length best_start               | out of block
//
// Each item runs through a sequencer over registered memory reads, one access
// per port a cycle. A rejected append goes straight to the result; a match
// follows suffix links until a transition or the root is reached (a letter
// outside the alphabet skips the walk); an append clears the new state's row,
// walks the links, checks the state a transition leads to, and, when a clone
// is made, copies that state's row and redirects links. in_ready is high only
// when idle. After reset a clearing pass zeroes the root row and node.
// A full result register holds the sequencer in its last step until taken.
module suffix_automaton_matcher #(
  parameter int unsigned MAX_TEXT = 1024,
  parameter int unsigned ALPHABET = 26
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic op,
  input  logic [sam_pkg::SymW-1:0] symbol,
  input  logic restart,
  output logic out_valid,
  input  logic out_ready,
  output logic status,
  output logic [11:0] states_used,
  output logic [10:0] match_length,
  output logic [10:0] best_length,
  output logic [9:0] best_start
);
  import sam_pkg::*;
  `include "suffix_automaton_matcher_defines.svh"

  localparam int unsigned PW = $clog2(MAX_TEXT);
  localparam int unsigned SW = PW + 1;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned AW = $clog2(ALPHABET);

  sam_state_t state, state_next;

  // Architectural registers
  logic [SW-1:0] last_state, walk_state, best_state, p, q, cur, cl;
  logic [SW-1:0] cur_len, cur_link, len_p, len_q;
  logic [PW-1:0] pos_q;
  logic [CW-1:0] state_total;
  logic [SW-1:0] text_length, walk_length, best_len;
  logic [AW-1:0] c, idx;
  logic          in_op, in_rst, in_bad, stat, fell;
  logic          clear_done;

  // Result register
  logic          stat_o;
  logic [CW-1:0] total_o;
  logic [SW-1:0] match_o, best_o;
  logic [PW-1:0] start_o;

  // Memory ports
  logic          tr_we, nd_we;
  logic [SW-1:0] tr_wstate, tr_wdata, tr_rstate, tr_rdata;
  logic [AW-1:0] tr_wsym, tr_rsym;
  logic [SW-1:0] nd_waddr, nd_wlen, nd_wlink, nd_raddr, nd_rlen, nd_rlink;
  logic [PW-1:0] nd_wpos, nd_rpos;

  sam_store #(.SW(SW), .PW(PW), .AW(AW), .ALPHABET(ALPHABET)) u_store (
    .clk, .tr_we, .tr_wstate, .tr_wsym, .tr_wdata, .tr_rstate, .tr_rsym,
    .tr_rdata, .nd_we, .nd_waddr, .nd_wlen, .nd_wlink, .nd_wpos, .nd_raddr,
    .nd_rlen, .nd_rlink, .nd_rpos
  );

  // Shared adder: operand pair chosen by state
  logic [SW-1:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic in_xfer, out_xfer, out_free, sym_ok, last_idx;
  assign in_ready = (state == ST_IDLE) && clear_done;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign out_free = !out_valid || out_ready;
  assign sym_ok   = {{(9-SymW){1'b0}}, symbol} < 9'(ALPHABET);
  assign last_idx = idx == AW'(ALPHABET - 1);

  // Outputs from the result register
  assign status       = stat_o;
  assign states_used  = 12'(total_o);
  assign match_length = 11'(match_o);
  assign best_length  = 11'(best_o);
  assign best_start   = 10'(start_o);

  // Sequencer: next state and memory port control
  always_comb begin
    state_next = state;
    tr_we = 1'b0; tr_wstate = p; tr_wsym = c; tr_wdata = cur;
    tr_rstate = p; tr_rsym = c;
    nd_we = 1'b0; nd_waddr = cur; nd_wlen = cur_len; nd_wlink = cur_link;
    nd_wpos = PW'(text_length); nd_raddr = p;
    add_a = len_p; add_b = SW'(1);
    unique case (state)
      ST_IDLE: if (in_xfer) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        nd_raddr = last_state;
        if (in_op == OP_MATCH) state_next = in_bad ? ST_MA_DONE : ST_MA_RD;
        else if (stat == STAT_FULL) state_next = ST_START;
        else state_next = ST_AP_CLR;
      end
      // Clear the new state's row; length of last_state is on nd_rlen
      ST_AP_CLR: begin
        tr_we = 1'b1; tr_wstate = cur; tr_wsym = idx; tr_wdata = '0;
        add_a = nd_rlen;
        if (last_idx) state_next = ST_AP_RDP;
      end
      ST_AP_RDP: state_next = ST_AP_CHKP;
      // Missing transition: point it at the new state and follow the link
      ST_AP_CHKP: begin
        if (tr_rdata == '0) begin
          tr_we = 1'b1;
          state_next = (p == '0) ? ST_AP_FIN : ST_AP_RDP;
        end else state_next = ST_AP_RDQ;
      end
      ST_AP_RDQ: begin
        nd_raddr = q;
        state_next = ST_AP_CHKQ;
      end
      ST_AP_CHKQ: begin
        nd_raddr = q;
        if (add_y == nd_rlen) state_next = ST_AP_FIN;
        else begin
          // Create clone with q's link and end position
          nd_we = 1'b1; nd_waddr = cl; nd_wlen = add_y; nd_wlink = nd_rlink;
          nd_wpos = nd_rpos;
          state_next = ST_AP_COPYRD;
        end
      end
      ST_AP_COPYRD: begin
        tr_rstate = q; tr_rsym = idx;
        state_next = ST_AP_COPY;
      end
      ST_AP_COPY: begin
        tr_we = 1'b1; tr_wstate = cl; tr_wsym = idx; tr_wdata = tr_rdata;
        tr_rstate = q; tr_rsym = AW'(idx + 1'b1);
        if (last_idx) state_next = ST_AP_REDIR;
      end
      ST_AP_REDIR: state_next = ST_AP_REDIRW;
      // Redirect transitions into q over to the clone
      ST_AP_REDIRW: begin
        if (tr_rdata == q) begin
          tr_we = 1'b1; tr_wdata = cl;
          state_next = (p == '0) ? ST_AP_QLINK : ST_AP_REDIR;
        end else state_next = ST_AP_QLINK;
      end
      ST_AP_QLINK: begin
        nd_we = 1'b1; nd_waddr = q; nd_wlen = len_q; nd_wlink = cl;
        nd_wpos = pos_q;
        state_next = ST_AP_FIN;
      end
      // Write the new state's node with its final link
      ST_AP_FIN: begin
        nd_we = 1'b1;
        state_next = ST_START;
      end
      ST_MA_RD: begin
        tr_rstate = walk_state; nd_raddr = walk_state;
        state_next = ST_MA_CHK;
      end
      ST_MA_CHK: begin
        add_a = fell ? nd_rlen : walk_length;
        if (walk_state != '0 && tr_rdata == '0) state_next = ST_MA_RD;
        else state_next = ST_MA_DONE;
      end
      ST_MA_DONE: state_next = ST_START;
      ST_START: begin
        nd_raddr = best_state;
        state_next = ST_STARTW;
      end
      ST_STARTW: begin
        nd_raddr = best_state;
        add_a = SW'(nd_rpos); add_b = SW'(1) - best_len;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
    // Root row and root node clear after reset
    if (!clear_done) begin
      tr_we = 1'b1; tr_wstate = '0; tr_wsym = idx; tr_wdata = '0;
      nd_we = 1'b1; nd_waddr = '0; nd_wlen = '0; nd_wlink = '0; nd_wpos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_state <= '0; state_total <= CW'(1); text_length <= '0;
      walk_state <= '0; walk_length <= '0; best_len <= '0; best_state <= '0;
      idx <= '0; clear_done <= 1'b0;
    end else if (!clear_done) begin
      idx <= last_idx ? '0 : AW'(idx + 1'b1);
      clear_done <= last_idx;
    end else begin
      unique case (state)
        ST_IDLE: if (in_xfer) begin
          in_op <= op; in_rst <= restart; in_bad <= !sym_ok; c <= AW'(symbol);
          stat <= (op == OP_APPEND &&
                   (text_length >= SW'(MAX_TEXT) || !sym_ok)) ? STAT_FULL : STAT_OK;
        end
        ST_DISPATCH: begin
          cur <= SW'(state_total); cl <= SW'(state_total + 1'b1);
          p <= last_state; idx <= '0; cur_link <= '0; fell <= 1'b0;
          if (in_op == OP_MATCH) begin
            // Restart or a letter outside the alphabet drops the walk
            if (in_rst || in_bad) begin
              walk_state <= '0; walk_length <= '0;
            end
            if (in_rst) begin
              best_len <= '0; best_state <= '0;
            end
          end
        end
        ST_AP_CLR: begin
          idx <= last_idx ? '0 : AW'(idx + 1'b1);
          cur_len <= add_y;
          if (last_idx) state_total <= state_total + 1'b1;
        end
        ST_AP_CHKP: begin
          if (tr_rdata == '0) p <= nd_rlink;
          else begin
            q <= tr_rdata; len_p <= nd_rlen;
          end
        end
        ST_AP_CHKQ: begin
          if (add_y == nd_rlen) cur_link <= q;
          else begin
            len_q <= nd_rlen; pos_q <= nd_rpos; idx <= '0;
            state_total <= state_total + 1'b1;
          end
        end
        ST_AP_COPY: idx <= last_idx ? '0 : AW'(idx + 1'b1);
        ST_AP_REDIRW: if (tr_rdata == q) p <= nd_rlink;
        ST_AP_QLINK: cur_link <= cl;
        ST_AP_FIN: begin
          last_state <= cur; text_length <= text_length + 1'b1;
        end
        // Fall back along the link, step on a hit, or drop to the root
        ST_MA_CHK: begin
          if (walk_state != '0 && tr_rdata == '0) begin
            walk_state <= nd_rlink; fell <= 1'b1;
          end else if (tr_rdata != '0) begin
            walk_state <= tr_rdata; walk_length <= add_y;
          end else begin
            walk_state <= '0; walk_length <= '0;
          end
        end
        ST_MA_DONE: if (walk_length > best_len) begin
          best_len <= walk_length; best_state <= walk_state;
        end
        default: ;
      endcase
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_STARTW && out_free) out_valid <= 1'b1;
    else if (out_xfer) out_valid <= 1'b0;
  end

  // Result fields, loaded when the register is free
  always_ff @(posedge clk) begin
    if (state == ST_STARTW && out_free) begin
      stat_o  <= stat;
      total_o <= state_total;
      match_o <= walk_length;
      best_o  <= best_len;
      start_o <= (best_len != '0) ? add_y[PW-1:0] : '0;
    end
  end

  `SAM_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, !in_ready, "accept while busy")
  `SAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `SAM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(best_start), "result changed")
  `SAM_ASSERT_IMP(a_total_grows, state == ST_AP_FIN, state_total > CW'(1), "no states")
endmodule
